// ----- rtl/pf_pkg.sv -----
// Shared types, constants and helpers for the Playfair digraph cipher.
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    localparam int DEF_MAX_KEY_LETTERS = 12;
    localparam int SIDE                = 5;
    localparam int CELLS               = 25;
    localparam int LETTERS             = 26;
    localparam int LETTER_W            = 5;
    localparam int RC_W                = 3;
    localparam int KEY_LEN_W           = 4;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    // "monarchy", first letter in the low bits
    localparam logic [59:0]          DEF_KEY_TEXT   = 60'd832234862028;
    localparam logic [KEY_LEN_W-1:0] DEF_KEY_LENGTH = 4'd8;

    localparam logic REG_KEY_TEXT   = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    // one square entry written by the builder
    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] idx;
        logic [RC_W-1:0]     row;
        logic [RC_W-1:0]     col;
    } pf_wr_t;

    // out-of-range codes become z, j becomes i
    function automatic logic [LETTER_W-1:0] clamp_letter(input logic [LETTER_W-1:0] c);
        logic [LETTER_W-1:0] r;
        r = (c > LETTER_Z) ? LETTER_Z : c;
        if (r == LETTER_J)
        begin
            r = LETTER_I;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pf_builder.sv -----
// Square builder: walks key letters then the alphabet, one candidate per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pf_builder
    import pf_pkg::*;
#(
    parameter int MAX_KEY_LETTERS = DEF_MAX_KEY_LETTERS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [5*MAX_KEY_LETTERS-1:0] key_text,
    input  wire logic [KEY_LEN_W-1:0]         key_length,
    output pf_wr_t                            wr,
    output logic                              busy
);

    localparam int KEY_W  = 5 * MAX_KEY_LETTERS;
    localparam int STEPS  = MAX_KEY_LETTERS + LETTERS;
    localparam int CNT_W  = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST     = CNT_W'(STEPS - 1);
    localparam logic [CNT_W-1:0] KEY_END  = CNT_W'(MAX_KEY_LETTERS);
    localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(MAX_KEY_LETTERS);
    localparam logic [LETTERS-1:0] USED_INIT = LETTERS'(1) << LETTER_J;

    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LETTERS-1:0]     used_reg, used_next;
    logic [LETTER_W-1:0]    n_reg, n_next;
    logic [RC_W-1:0]        row_reg, row_next;
    logic [RC_W-1:0]        col_reg, col_next;

    logic [KEY_LEN_W-1:0]   len_eff;
    logic                   key_phase;
    logic [LETTER_W-1:0]    raw;
    logic [LETTER_W-1:0]    cand;
    logic                   cand_ok;
    logic [LETTER_W-1:0]    letter;
    logic                   take;
    logic [KEY_W-1:0]       key_shift;

    always_comb
    begin
        len_eff   = (key_length > LEN_MAX) ? LEN_MAX : key_length;
        key_phase = cnt_reg < KEY_END;
        key_shift = key_text >> (32'(cnt_reg) * 5);
        raw       = key_shift[LETTER_W-1:0];
        if (key_phase)
        begin
            cand    = raw;
            cand_ok = (cnt_reg < CNT_W'(len_eff)) && (raw <= LETTER_Z);
        end
        else
        begin
            cand    = LETTER_W'(cnt_reg - KEY_END);
            cand_ok = 1'b1;
        end
        letter = (cand == LETTER_J) ? LETTER_I : cand;
        take   = busy_reg && cand_ok && !used_reg[letter] && (n_reg < LETTER_W'(CELLS));
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        used_next = used_reg;
        n_next    = n_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            used_next = USED_INIT;
            n_next    = '0;
            row_next  = '0;
            col_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
            if (take)
            begin
                used_next[letter] = 1'b1;
                n_next            = n_reg + 1'b1;
                if (col_reg == RC_W'(SIDE - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            used_reg <= USED_INIT;
            n_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            used_reg <= used_next;
            n_reg    <= n_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    assign wr.we     = take && !start;
    assign wr.letter = letter;
    assign wr.idx    = n_reg;
    assign wr.row    = row_reg;
    assign wr.col    = col_reg;
    assign busy      = busy_reg;

endmodule

`default_nettype wire

// ----- rtl/pf_core.sv -----
// Cipher datapath: position lookup, Playfair rules, letter lookup.
`timescale 1ns / 1ps
`default_nettype none

module pf_core
    import pf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                advance,
    input  wire logic                func,
    input  wire logic [LETTER_W-1:0] first_letter,
    input  wire logic [LETTER_W-1:0] second_letter,
    input  wire pf_wr_t              wr,
    output logic [LETTER_W-1:0]      first_out,
    output logic [LETTER_W-1:0]      second_out
);

    localparam int POS_W = 2 * RC_W;

    logic [POS_W-1:0]    where_mem [0:LETTERS-1];
    logic [LETTER_W-1:0] cell_mem  [0:CELLS-1];

    logic [POS_W-1:0]    pa_reg, pb_reg;
    logic                dec_reg;
    logic [LETTER_W-1:0] first_out_reg, second_out_reg;

    logic [RC_W-1:0]     ra, ca, rb, cb;
    logic [RC_W-1:0]     ora, oca, orb, ocb;
    logic [LETTER_W-1:0] oa, ob;

    function automatic logic [RC_W-1:0] step5(input logic [RC_W-1:0] x, input logic dec);
        logic [RC_W-1:0] r;
        if (dec)
        begin
            r = (x == '0) ? RC_W'(SIDE - 1) : x - 1'b1;
        end
        else
        begin
            r = (x == RC_W'(SIDE - 1)) ? '0 : x + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] lin(input logic [RC_W-1:0] r,
                                               input logic [RC_W-1:0] c);
        return {r, 2'b00} + LETTER_W'(r) + LETTER_W'(c);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            where_mem[wr.letter] <= {wr.row, wr.col};
            cell_mem[wr.idx]     <= wr.letter;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg  <= where_mem[clamp_letter(first_letter)];
            pb_reg  <= where_mem[clamp_letter(second_letter)];
            dec_reg <= func;
        end
    end

    always_comb
    begin
        {ra, ca} = pa_reg;
        {rb, cb} = pb_reg;
        if (ra == rb)
        begin
            ora = ra;
            oca = step5(ca, dec_reg);
            orb = rb;
            ocb = step5(cb, dec_reg);
        end
        else if (ca == cb)
        begin
            ora = step5(ra, dec_reg);
            oca = ca;
            orb = step5(rb, dec_reg);
            ocb = cb;
        end
        else
        begin
            ora = ra;
            oca = cb;
            orb = rb;
            ocb = ca;
        end
        oa = lin(ora, oca);
        ob = lin(orb, ocb);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_out_reg  <= cell_mem[oa];
            second_out_reg <= cell_mem[ob];
        end
    end

    assign first_out  = first_out_reg;
    assign second_out = second_out_reg;

endmodule

`default_nettype wire

// ----- rtl/playfair_digraph_cipher.sv -----
// Top level of the Playfair digraph cipher: config registers, handshake, builder and datapath.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  in      | in  | in_valid / in_stall | func, first_letter, second_letter
//  out     | out | out_valid/out_stall | first_out, second_out
//  cfg     | in  | cfg_wr_en           | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; an item goes via s1_valid_reg to out_valid_reg.
//  The rate is set by the two-stage memory pipeline (position read, letter read).
//  After reset and after every config write the square is rebuilt from the key letters and
//  then the alphabet, with in_stall held high.
//  out_stall freezes the whole pipeline while out_valid is high; in_stall follows it.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher
    import pf_pkg::*;
#(
    parameter int MAX_KEY_LETTERS = DEF_MAX_KEY_LETTERS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         func,
    input  wire logic [LETTER_W-1:0]          first_letter,
    input  wire logic [LETTER_W-1:0]          second_letter,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [LETTER_W-1:0]               first_out,
    output logic [LETTER_W-1:0]               second_out,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [5*MAX_KEY_LETTERS-1:0] cfg_data
);

    localparam int KEY_W = 5 * MAX_KEY_LETTERS;

    logic [KEY_W-1:0]     key_text_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 advance;
    logic                 busy;
    pf_wr_t               wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= KEY_W'(DEF_KEY_TEXT);
            key_length_reg <= DEF_KEY_LENGTH;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_TEXT:   key_text_reg   <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default:        key_text_reg   <= key_text_reg;
            endcase
        end
    end

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = busy || !advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = in_valid && !busy;
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pf_builder #(
        .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
    ) u_builder (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_wr_en),
        .key_text   (key_text_reg),
        .key_length (key_length_reg),
        .wr         (wr),
        .busy       (busy)
    );

    pf_core u_core (
        .clk           (clk),
        .advance       (advance),
        .func          (func),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .wr            (wr),
        .first_out     (first_out),
        .second_out    (second_out)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/pf_checker.sv -----
// Port-level checker for the Playfair digraph cipher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pf_checker
    import pf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [LETTER_W-1:0] first_out,
    input wire logic [LETTER_W-1:0] second_out,
    input wire logic                cfg_wr_en
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_out) && $stable(second_out))
        else $error("stalled result changed");

    // square rebuild blocks input after a config write
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> in_stall)
        else $error("input taken while square rebuilds");

    // an accepted item reaches out_valid through the stage-one and output valid registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("item lost in pipeline");

    // results are letters of the square: never j, never above z
    a_letters: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> first_out != LETTER_J && second_out != LETTER_J
                      && first_out <= LETTER_Z && second_out <= LETTER_Z)
        else $error("result outside the square");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .first_out  (first_out),
    .second_out (second_out),
    .cfg_wr_en  (cfg_wr_en)
);

`default_nettype wire
